// File: hdl/blr_pkg.sv
// Shared types, constants and helpers for the Bresenham line rasterizer.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package blr_pkg;

  localparam int CoordWidth = 16;
  localparam int DeltaWidth = CoordWidth + 1;
  localparam int ErrWidth   = CoordWidth + 2;
  localparam int ColorWidth = 32;
  localparam int OffWidth   = 32;
  localparam int PitchWidth = 18;
  localparam int DepthWidth = 6;
  localparam int CfgIdxWidth  = 3;
  localparam int CfgDataWidth = 18;

  localparam int QDepth    = 4;
  localparam int QPtrWidth = $clog2(QDepth);
  localparam int QCntWidth = $clog2(QDepth + 1);

  localparam logic [DepthWidth-1:0] WriteDepth = DepthWidth'(32);
  localparam logic [ColorWidth-1:0] KeepMask   = 32'hFF00FF00;
  localparam logic [ColorWidth-1:0] RedMask    = 32'h00FF0000;
  localparam logic [ColorWidth-1:0] BlueMask   = 32'h000000FF;

  localparam logic signed [15:0] ResetClipLeft   = 16'sd0;
  localparam logic signed [15:0] ResetClipTop    = 16'sd0;
  localparam logic [15:0]        ResetClipWidth  = 16'd1024;
  localparam logic [15:0]        ResetClipHeight = 16'd768;
  localparam logic [PitchWidth-1:0] ResetPitch   = PitchWidth'(4096);

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_CLIP_LEFT   = 3'd0,
    CFG_CLIP_TOP    = 3'd1,
    CFG_CLIP_WIDTH  = 3'd2,
    CFG_CLIP_HEIGHT = 3'd3,
    CFG_ROW_PITCH   = 3'd4,
    CFG_SWAP_RB     = 3'd5,
    CFG_PIXEL_DEPTH = 3'd6
  } cfg_idx_t;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_t;

  typedef struct packed {
    logic                         command;
    logic signed [CoordWidth-1:0] start_x;
    logic signed [CoordWidth-1:0] start_y;
    logic signed [CoordWidth-1:0] end_x;
    logic signed [CoordWidth-1:0] end_y;
    logic [ColorWidth-1:0]        line_color;
  } in_item_t;

  typedef struct packed {
    logic signed [CoordWidth-1:0] pixel_x;
    logic signed [CoordWidth-1:0] pixel_y;
    logic [OffWidth-1:0]          byte_offset;
    logic [ColorWidth-1:0]        pixel_color;
    logic                         write_enable;
    logic                         last_pixel;
  } out_item_t;

  typedef struct packed {
    logic signed [CoordWidth-1:0] x;
    logic signed [CoordWidth-1:0] y;
    logic [ColorWidth-1:0]        color;
    logic                         last;
  } pix_t;

  typedef struct packed {
    logic signed [15:0]    clip_left;
    logic signed [15:0]    clip_top;
    logic [15:0]           clip_width;
    logic [15:0]           clip_height;
    logic [PitchWidth-1:0] row_pitch;
    logic                  swap_red_blue;
    logic [DepthWidth-1:0] pixel_depth;
  } cfg_t;

  function automatic logic [ColorWidth-1:0] swap_rb(input logic [ColorWidth-1:0] c);
    swap_rb = (c & KeepMask) | ((c & RedMask) >> 16) | ((c & BlueMask) << 16);
  endfunction

endpackage

`default_nettype wire

// File: hdl/blr_queue.sv
// Small FIFO of pixel records between the stepper and the pixel back end.
// Depends on blr_pkg.
`default_nettype none

module blr_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  blr_pkg::pix_t      push_data,
  output logic               full,
  input  wire logic          pop,
  output logic               empty,
  output blr_pkg::pix_t      head
);

  blr_pkg::pix_t                        mem [blr_pkg::QDepth];
  logic [blr_pkg::QPtrWidth-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [blr_pkg::QPtrWidth-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [blr_pkg::QCntWidth-1:0]        cnt_r, cnt_nxt;
  logic                                 do_push, do_pop;

  assign full    = (cnt_r == blr_pkg::QCntWidth'(blr_pkg::QDepth));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: hdl/blr_front.sv
// Front end: takes commands, holds the Bresenham line state and emits one
// pixel record per step into the pixel queue. Depends on blr_pkg.
`default_nettype none

module blr_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_push,
  input  blr_pkg::in_item_t  in_item,
  output logic               in_full,
  input  wire logic          q_full,
  output logic               q_push,
  output blr_pkg::pix_t      q_data
);

  localparam int CW = blr_pkg::CoordWidth;
  localparam int DW = blr_pkg::DeltaWidth;
  localparam int EW = blr_pkg::ErrWidth;

  logic signed [CW-1:0] cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic signed [CW-1:0] tgt_x_r, tgt_x_nxt, tgt_y_r, tgt_y_nxt;
  logic [DW-1:0]        dx_r, dx_nxt, dy_r, dy_nxt;
  logic signed [EW-1:0] err_r, err_nxt;
  logic                 sxn_r, sxn_nxt, syn_r, syn_nxt;
  logic [blr_pkg::ColorWidth-1:0] color_r, color_nxt;
  logic                 busy_r, busy_nxt;

  logic                 accept, is_step;
  logic signed [DW-1:0] diff_x, diff_y;
  logic signed [EW:0]   e2, neg_dy, err_wide;
  logic                 move_x, move_y, last;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;
  assign is_step = (in_item.command == blr_pkg::CMD_STEP);
  assign last    = (cur_x_r == tgt_x_r) && (cur_y_r == tgt_y_r);
  assign q_push  = accept && is_step && busy_r;
  assign q_data  = '{x: cur_x_r, y: cur_y_r, color: color_r, last: last};

  always_comb begin
    diff_x   = DW'(in_item.end_x) - DW'(in_item.start_x);
    diff_y   = DW'(in_item.end_y) - DW'(in_item.start_y);
    e2       = {err_r, 1'b0};
    neg_dy   = -$signed({2'b00, dy_r});
    move_x   = e2 > neg_dy;
    move_y   = e2 < $signed({2'b00, dx_r});
    err_wide = (EW+1)'(err_r);
    if (move_x) begin
      err_wide = err_wide - $signed({2'b00, dy_r});
    end
    if (move_y) begin
      err_wide = err_wide + $signed({2'b00, dx_r});
    end

    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    tgt_x_nxt = tgt_x_r;
    tgt_y_nxt = tgt_y_r;
    dx_nxt    = dx_r;
    dy_nxt    = dy_r;
    err_nxt   = err_r;
    sxn_nxt   = sxn_r;
    syn_nxt   = syn_r;
    color_nxt = color_r;
    busy_nxt  = busy_r;

    if (accept && !is_step) begin
      cur_x_nxt = in_item.start_x;
      cur_y_nxt = in_item.start_y;
      tgt_x_nxt = in_item.end_x;
      tgt_y_nxt = in_item.end_y;
      dx_nxt    = diff_x[DW-1] ? DW'(-diff_x) : DW'(diff_x);
      dy_nxt    = diff_y[DW-1] ? DW'(-diff_y) : DW'(diff_y);
      sxn_nxt   = diff_x[DW-1] || (diff_x == '0);
      syn_nxt   = diff_y[DW-1] || (diff_y == '0);
      err_nxt   = $signed({1'b0, dx_nxt}) - $signed({1'b0, dy_nxt});
      color_nxt = in_item.line_color;
      busy_nxt  = 1'b1;
    end else if (q_push) begin
      if (last) begin
        busy_nxt = 1'b0;
      end else begin
        err_nxt = EW'(err_wide);
        if (move_x) begin
          cur_x_nxt = sxn_r ? cur_x_r - 1'b1 : cur_x_r + 1'b1;
        end
        if (move_y) begin
          cur_y_nxt = syn_r ? cur_y_r - 1'b1 : cur_y_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_x_r <= cur_x_nxt;
    cur_y_r <= cur_y_nxt;
    tgt_x_r <= tgt_x_nxt;
    tgt_y_r <= tgt_y_nxt;
    dx_r    <= dx_nxt;
    dy_r    <= dy_nxt;
    err_r   <= err_nxt;
    sxn_r   <= sxn_nxt;
    syn_r   <= syn_nxt;
    color_r <= color_nxt;
  end

endmodule

`default_nettype wire

// File: hdl/blr_back.sv
// Back end: clip test, row multiply and colour swap in one registered stage,
// then offset add into the result FIFO. Depends on blr_pkg.
`default_nettype none

module blr_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  blr_pkg::cfg_t       cfg,
  input  wire logic           q_empty,
  input  blr_pkg::pix_t       q_head,
  output logic                q_pop,
  input  wire logic           out_pop,
  output logic                out_empty,
  output blr_pkg::out_item_t  out_item
);

  localparam int CW = blr_pkg::CoordWidth;
  localparam int OW = blr_pkg::OffWidth;
  localparam int PW = blr_pkg::PitchWidth;

  // stage 1
  logic                 s1_v_r;
  logic signed [CW-1:0] s1_x_r, s1_y_r;
  logic [OW-1:0]        s1_prod_r;
  logic [blr_pkg::ColorWidth-1:0] s1_color_r;
  logic                 s1_we_r, s1_last_r;

  logic signed [CW+1:0]    rel_x, rel_y;
  logic                    in_clip;
  logic signed [CW+PW:0]   prod;
  logic [OW-1:0]           offset;
  blr_pkg::out_item_t      res;

  // result FIFO
  blr_pkg::out_item_t                mem [blr_pkg::QDepth];
  logic [blr_pkg::QPtrWidth-1:0]     wr_ptr_r, rd_ptr_r;
  logic [blr_pkg::QCntWidth-1:0]     cnt_r, cnt_nxt;
  logic                              do_pop;

  assign q_pop = !q_empty &&
                 ((cnt_r + blr_pkg::QCntWidth'(s1_v_r)) <
                  blr_pkg::QCntWidth'(blr_pkg::QDepth));

  always_comb begin
    rel_x   = (CW+2)'(q_head.x) - (CW+2)'(cfg.clip_left);
    rel_y   = (CW+2)'(q_head.y) - (CW+2)'(cfg.clip_top);
    in_clip = !rel_x[CW+1] && (rel_x < $signed({2'b00, cfg.clip_width})) &&
              !rel_y[CW+1] && (rel_y < $signed({2'b00, cfg.clip_height}));
    prod    = q_head.y * $signed({1'b0, cfg.row_pitch});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_x_r     <= q_head.x;
      s1_y_r     <= q_head.y;
      s1_prod_r  <= prod[OW-1:0];
      s1_color_r <= cfg.swap_red_blue ? blr_pkg::swap_rb(q_head.color) : q_head.color;
      s1_we_r    <= in_clip && (cfg.pixel_depth == blr_pkg::WriteDepth);
      s1_last_r  <= q_head.last;
    end
  end

  always_comb begin
    offset = s1_prod_r + (OW'(s1_x_r) << 2);
    res    = '{pixel_x:      s1_x_r,
               pixel_y:      s1_y_r,
               byte_offset:  s1_we_r ? offset : '0,
               pixel_color:  s1_color_r,
               write_enable: s1_we_r,
               last_pixel:   s1_last_r};
  end

  assign out_empty = (cnt_r == '0);
  assign do_pop    = out_pop && !out_empty;
  assign out_item  = mem[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (s1_v_r && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !s1_v_r) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (s1_v_r) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      mem[wr_ptr_r] <= res;
    end
  end

endmodule

`default_nettype wire

// File: hdl/bresenham_line_rasterizer.sv
// Top level of the Bresenham line rasterizer: configuration registers and
// the front end, pixel queue and back end. Depends on blr_pkg, blr_front,
// blr_queue and blr_back.
//
// Input queue: drive in_item and raise in_push; the transaction is taken on
// a clock edge with in_full low. A start command loads a line and yields no
// result; each step command while a line is active yields one pixel.
// Result queue: while out_empty is low the oldest pixel is on out_item; raise
// out_pop to take it. last_pixel marks the end point of the line.
// A step's pixel passes the pixel queue, back-end register and result FIFO.
// One transaction is taken per clock while in_full is low; the stepper updates
// its error term and coordinates per step; the y*pitch multiply is registered.
// If the receiver stalls, four pixels collect in the result FIFO and four in
// the pixel queue, after which in_full rises until out_pop resumes.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
// belong only in idle periods. Synchronous reset (rst_n low) empties both
// queues, drops any active line and restores the register defaults.
`default_nettype none

module bresenham_line_rasterizer (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_push,
  input  blr_pkg::in_item_t                         in_item,
  output logic                                      in_full,
  output logic                                      out_empty,
  input  wire logic                                 out_pop,
  output blr_pkg::out_item_t                        out_item,
  input  wire logic                                 cfg_we,
  input  wire logic [blr_pkg::CfgIdxWidth-1:0]      cfg_index,
  input  wire logic [blr_pkg::CfgDataWidth-1:0]     cfg_data
);

  blr_pkg::cfg_t cfg_r;
  blr_pkg::pix_t fq_data, q_head;
  logic          fq_push, q_full, q_pop, q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.clip_left     <= blr_pkg::ResetClipLeft;
      cfg_r.clip_top      <= blr_pkg::ResetClipTop;
      cfg_r.clip_width    <= blr_pkg::ResetClipWidth;
      cfg_r.clip_height   <= blr_pkg::ResetClipHeight;
      cfg_r.row_pitch     <= blr_pkg::ResetPitch;
      cfg_r.swap_red_blue <= 1'b0;
      cfg_r.pixel_depth   <= blr_pkg::WriteDepth;
    end else if (cfg_we) begin
      unique case (blr_pkg::cfg_idx_t'(cfg_index))
        blr_pkg::CFG_CLIP_LEFT:   cfg_r.clip_left     <= $signed(cfg_data[15:0]);
        blr_pkg::CFG_CLIP_TOP:    cfg_r.clip_top      <= $signed(cfg_data[15:0]);
        blr_pkg::CFG_CLIP_WIDTH:  cfg_r.clip_width    <= cfg_data[15:0];
        blr_pkg::CFG_CLIP_HEIGHT: cfg_r.clip_height   <= cfg_data[15:0];
        blr_pkg::CFG_ROW_PITCH:   cfg_r.row_pitch     <= cfg_data;
        blr_pkg::CFG_SWAP_RB:     cfg_r.swap_red_blue <= cfg_data[0];
        blr_pkg::CFG_PIXEL_DEPTH: cfg_r.pixel_depth   <= cfg_data[blr_pkg::DepthWidth-1:0];
        default: ;
      endcase
    end
  end

  blr_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_item (in_item),
    .in_full (in_full),
    .q_full  (q_full),
    .q_push  (fq_push),
    .q_data  (fq_data)
  );

  blr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fq_push),
    .push_data (fq_data),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  blr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

// File: tb/sv/tb_bresenham_line_rasterizer.sv
// Self-checking testbench for bresenham_line_rasterizer: queued line commands,
// an in-bench line stepper that predicts each pixel, and a field-by-field check.
// Depends on blr_pkg and the bresenham_line_rasterizer RTL.
`default_nettype none

module tb_bresenham_line_rasterizer;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  blr_pkg::in_item_t in_item = '0;
  logic in_full;
  logic out_empty;
  logic out_pop = 1'b0;
  blr_pkg::out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [blr_pkg::CfgIdxWidth-1:0] cfg_index = '0;
  logic [blr_pkg::CfgDataWidth-1:0] cfg_data = '0;

  bresenham_line_rasterizer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_item   (in_item),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  blr_pkg::in_item_t  pending_commands[$];
  blr_pkg::out_item_t expected_pixels[$];
  blr_pkg::out_item_t popped_pixel;
  int        mismatch_count = 0;
  bit        in_taken = 1'b0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        hold_request = 0;
  int        hold_seen = 0;
  int        hold_left = 0;

  // shadow of the registers and of the line stepper
  blr_pkg::cfg_t      model_cfg;
  logic signed [15:0] line_x, line_y, goal_x, goal_y;
  int                 span_x, span_y, line_err;
  bit                 x_back, y_back, line_active;
  logic [31:0]        line_rgb;

  task automatic trace_line_step(input blr_pkg::in_item_t it);
    blr_pkg::out_item_t px;
    int          e2;
    longint      lx, ly, lo_x, lo_y, w, h;
    bit          in_clip;
    logic [31:0] ux, uy, off;
    if (it.command == blr_pkg::CMD_START) begin
      line_x = it.start_x;
      line_y = it.start_y;
      goal_x = it.end_x;
      goal_y = it.end_y;
      span_x = (it.end_x >= it.start_x) ? int'(it.end_x) - int'(it.start_x)
                                        : int'(it.start_x) - int'(it.end_x);
      span_y = (it.end_y >= it.start_y) ? int'(it.end_y) - int'(it.start_y)
                                        : int'(it.start_y) - int'(it.end_y);
      x_back = !(it.start_x < it.end_x);
      y_back = !(it.start_y < it.end_y);
      line_err = span_x - span_y;
      line_rgb = it.line_color;
      line_active = 1'b1;
    end else if (line_active) begin
      lx = line_x;
      ly = line_y;
      lo_x = model_cfg.clip_left;
      lo_y = model_cfg.clip_top;
      w = model_cfg.clip_width;
      h = model_cfg.clip_height;
      in_clip = lx >= lo_x && lx < lo_x + w && ly >= lo_y && ly < lo_y + h;
      ux = {{16{line_x[15]}}, line_x};
      uy = {{16{line_y[15]}}, line_y};
      off = uy * {14'd0, model_cfg.row_pitch} + ux * 32'd4;
      px.pixel_x = line_x;
      px.pixel_y = line_y;
      px.write_enable = in_clip && model_cfg.pixel_depth == blr_pkg::WriteDepth;
      px.byte_offset = px.write_enable ? off : '0;
      px.pixel_color = model_cfg.swap_red_blue
                       ? {line_rgb[31:24], line_rgb[7:0], line_rgb[15:8], line_rgb[23:16]}
                       : line_rgb;
      px.last_pixel = line_x == goal_x && line_y == goal_y;
      expected_pixels.push_back(px);
      if (px.last_pixel) begin
        line_active = 1'b0;
      end else begin
        e2 = 2 * line_err;
        if (e2 > -span_y) begin
          line_err -= span_y;
          line_x = x_back ? line_x - 16'sd1 : line_x + 16'sd1;
        end
        if (e2 < span_x) begin
          line_err += span_x;
          line_y = y_back ? line_y - 16'sd1 : line_y + 16'sd1;
        end
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t %s mismatch: expected %h actual %h", $time, name, want, got);
    end
  endtask

  // input accepted / result accepted, both sampled at the rising edge
  always @(posedge clk) begin
    in_taken = rst_n && in_push && !in_full;
    if (in_taken) begin
      trace_line_step(in_item);
    end
    if (rst_n && out_pop && !out_empty) begin
      if (expected_pixels.size() == 0) begin
        mismatch_count++;
        $display("%0t unexpected pixel: expected none actual %p", $time, out_item);
      end else begin
        popped_pixel = expected_pixels.pop_front();
        check_field("pixel_x", {16'd0, popped_pixel.pixel_x}, {16'd0, out_item.pixel_x});
        check_field("pixel_y", {16'd0, popped_pixel.pixel_y}, {16'd0, out_item.pixel_y});
        check_field("byte_offset", popped_pixel.byte_offset, out_item.byte_offset);
        check_field("pixel_color", popped_pixel.pixel_color, out_item.pixel_color);
        check_field("write_enable", {31'd0, popped_pixel.write_enable},
                    {31'd0, out_item.write_enable});
        check_field("last_pixel", {31'd0, popped_pixel.last_pixel},
                    {31'd0, out_item.last_pixel});
      end
    end
  end

  // input driver
  always @(negedge clk) begin
    if (rst_n && (!in_push || in_taken)) begin
      if (pending_commands.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_item <= pending_commands.pop_front();
        in_push <= 1'b1;
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // result receiver, with one long hold-off
  always @(negedge clk) begin
    if (hold_seen != hold_request) begin
      hold_seen = hold_request;
      hold_left = 120;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_pop <= 1'b0;
    end else begin
      out_pop <= $urandom_range(99) >= recv_stall_pct;
    end
  end

  function automatic int clamp_coord(input int v);
    return (v > 32767) ? 32767 : (v < -32768) ? -32768 : v;
  endfunction

  function automatic int rand_coord();
    return int'($urandom_range(65535)) - 32768;
  endfunction

  task automatic add_start(input int sx, input int sy, input int ex, input int ey,
                           input logic [31:0] rgb);
    blr_pkg::in_item_t it;
    it.command = blr_pkg::CMD_START;
    it.start_x = 16'(sx);
    it.start_y = 16'(sy);
    it.end_x = 16'(ex);
    it.end_y = 16'(ey);
    it.line_color = rgb;
    pending_commands.push_back(it);
  endtask

  task automatic add_steps(input int n);
    blr_pkg::in_item_t it;
    logic [127:0]      noise;
    repeat (n) begin
      noise = {$urandom, $urandom, $urandom, $urandom};
      it = blr_pkg::in_item_t'(noise[$bits(blr_pkg::in_item_t)-1:0]);
      it.command = blr_pkg::CMD_STEP;
      pending_commands.push_back(it);
    end
  endtask

  task automatic queue_random_lines(input int n);
    int added, kind, len, sx, sy, ex, ey, ax, ay, pixels, steps;
    added = 0;
    while (added < n) begin
      kind = $urandom_range(99);
      if (kind < 8) begin
        add_start(rand_coord(), rand_coord(), rand_coord(), rand_coord(), $urandom);
        steps = $urandom_range(3);
        added += 1;
      end else if (kind < 10) begin
        steps = 1 + $urandom_range(1);
      end else begin
        if ($urandom_range(1)) begin
          sx = ($urandom_range(1) ? int'(model_cfg.clip_left)
                : int'(model_cfg.clip_left) + int'(model_cfg.clip_width))
               + int'($urandom_range(40)) - 20;
          sy = ($urandom_range(1) ? int'(model_cfg.clip_top)
                : int'(model_cfg.clip_top) + int'(model_cfg.clip_height))
               + int'($urandom_range(40)) - 20;
        end else begin
          sx = rand_coord();
          sy = rand_coord();
        end
        len = ($urandom_range(19) == 0) ? 300 : 24;
        ex = clamp_coord(sx + int'($urandom_range(2 * len)) - len);
        ey = clamp_coord(sy + int'($urandom_range(2 * len)) - len);
        sx = clamp_coord(sx);
        sy = clamp_coord(sy);
        ax = (ex > sx) ? ex - sx : sx - ex;
        ay = (ey > sy) ? ey - sy : sy - ey;
        pixels = ((ax > ay) ? ax : ay) + 1;
        kind = $urandom_range(9);
        if (kind == 0) steps = $urandom_range(pixels - 1);
        else if (kind == 1) steps = pixels + 1 + $urandom_range(2);
        else steps = pixels;
        add_start(sx, sy, ex, ey, $urandom);
        added += 1;
      end
      if (steps > n - added) steps = n - added;
      add_steps(steps);
      added += steps;
    end
  endtask

  // wait for the block to go idle, then let any trailing command settle
  task automatic drain();
    @(posedge clk);
    while (pending_commands.size() > 0 || in_push || expected_pixels.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic put_reg(input blr_pkg::cfg_idx_t idx,
                         input logic [blr_pkg::CfgDataWidth-1:0] d);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
  endtask

  task automatic set_config(input blr_pkg::cfg_t c);
    put_reg(blr_pkg::CFG_CLIP_LEFT, {2'b00, c.clip_left});
    put_reg(blr_pkg::CFG_CLIP_TOP, {2'b00, c.clip_top});
    put_reg(blr_pkg::CFG_CLIP_WIDTH, {2'b00, c.clip_width});
    put_reg(blr_pkg::CFG_CLIP_HEIGHT, {2'b00, c.clip_height});
    put_reg(blr_pkg::CFG_ROW_PITCH, c.row_pitch);
    put_reg(blr_pkg::CFG_SWAP_RB, {17'd0, c.swap_red_blue});
    put_reg(blr_pkg::CFG_PIXEL_DEPTH, {12'd0, c.pixel_depth});
    @(negedge clk);
    cfg_we <= 1'b0;
    model_cfg = c;
    @(posedge clk);
  endtask

  function automatic blr_pkg::cfg_t random_cfg();
    blr_pkg::cfg_t c;
    c.clip_left = 16'($urandom);
    c.clip_top = 16'($urandom);
    c.clip_width = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(2048));
    c.clip_height = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(2048));
    c.row_pitch = blr_pkg::PitchWidth'($urandom);
    c.swap_red_blue = 1'($urandom);
    c.pixel_depth = $urandom_range(3) == 0 ? blr_pkg::DepthWidth'($urandom)
                                           : blr_pkg::WriteDepth;
    return c;
  endfunction

  initial begin
    blr_pkg::cfg_t c;
    model_cfg = '{blr_pkg::ResetClipLeft, blr_pkg::ResetClipTop, blr_pkg::ResetClipWidth,
                  blr_pkg::ResetClipHeight, blr_pkg::ResetPitch, 1'b0,
                  blr_pkg::WriteDepth};
    line_active = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: idle step, one-pixel line, extremes, replaced line, clip edges
    add_steps(1);
    add_start(5, 5, 5, 5, 32'hAABBCCDD);
    add_steps(2);
    add_start(-32768, 32767, 32767, -32768, 32'hFFFFFFFF);
    add_steps(2);
    add_start(0, 0, 3, -2, 32'h00000000);
    add_steps(5);
    add_start(1023, 767, 1020, 770, 32'h12345678);
    add_steps(5);
    add_start(0, 0, 1, 5, 32'h80FF0001);
    add_steps(6);
    drain();

    for (int p = 1; p <= 8; p++) begin
      case (p)
        1: c = '{16'sh8000, 16'sh8000, 16'hFFFF, 16'hFFFF, 18'h3FFFF, 1'b1,
                 blr_pkg::WriteDepth};
        2: c = '{16'sd100, -16'sd50, 16'd0, 16'd300, 18'd0, 1'b0, 6'd0};
        3: c = '{16'sh7FFF, 16'sh7FFF, 16'd1, 16'd1, 18'd1, 1'b1, 6'd31};
        5: c = '{blr_pkg::ResetClipLeft, blr_pkg::ResetClipTop, blr_pkg::ResetClipWidth,
                 blr_pkg::ResetClipHeight, blr_pkg::ResetPitch, 1'b0,
                 blr_pkg::WriteDepth};
        default: c = random_cfg();
      endcase
      set_config(c);
      send_idle_pct = (p % 4 == 1) ? 67 : (p % 4 == 3) ? 10 : 0;
      recv_stall_pct = (p % 4 == 2) ? 67 : (p % 4 == 3) ? 10 : 0;
      if (p == 5) hold_request++;
      queue_random_lines(65);
      drain();
      queue_random_lines(65);
      drain();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();
    if (mismatch_count == 0 && expected_pixels.size() == 0) begin
      $display("bresenham_line_rasterizer verification clean");
    end else begin
      $display("bresenham_line_rasterizer verification failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("bresenham_line_rasterizer verification failed");
    $finish;
  end

endmodule

`default_nettype wire
